FILE: hdl/rrpm_pkg.sv
// Shared types, constants and register indexes for the rectangle mapping core.
package rrpm_pkg;

  localparam int CoordW = 16;
  localparam int RelW   = 17;
  localparam int ProdW  = 34;
  localparam int QuoW   = 34;
  localparam int NumCh  = 4;

  localparam logic [2:0] REG_SRC_LEFT   = 3'd0;
  localparam logic [2:0] REG_SRC_TOP    = 3'd1;
  localparam logic [2:0] REG_SRC_RIGHT  = 3'd2;
  localparam logic [2:0] REG_SRC_BOTTOM = 3'd3;
  localparam logic [2:0] REG_DST_LEFT   = 3'd4;
  localparam logic [2:0] REG_DST_TOP    = 3'd5;
  localparam logic [2:0] REG_DST_RIGHT  = 3'd6;
  localparam logic [2:0] REG_DST_BOTTOM = 3'd7;

  // One divider cell's state: partial remainder, quotient bits, sign info.
  typedef struct packed {
    logic [ProdW-1:0] rem;
    logic [QuoW-1:0]  quo;
    logic             neg;
  } div_lane_t;

  // Per-item control travelling alongside the divider lanes.
  typedef struct packed {
    logic                     vld;
    logic                     rect;
    logic                     mapped;
    logic [CoordW-1:0]        h_a;
    logic [CoordW-1:0]        v_a;
    logic [CoordW-1:0]        h_b;
    logic [CoordW-1:0]        v_b;
  } item_ctl_t;

endpackage

FILE: hdl/rect_to_rect_point_mapping_core.sv
// Top level: configuration registers, front multiply, divider cell chain, output stage.
// Pipeline: 37 registers from input transfer to result valid (2 front, 34 cells, 1 out).
// Throughput: one item per cycle; the whole chain advances whenever the output
// register is free or being taken, so a stalled output stalls the chain.
// Reset (rst_n, synchronous, active low) clears all valid flags and the eight
// rectangle registers to zero.
module rect_to_rect_point_mapping_core
  import rrpm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // in_h_a, in_v_a, in_h_b, in_v_b
  input  logic        in_tuser,   // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // out_h_a, out_v_a, out_h_b, out_v_b
  output logic        out_tuser,  // mapped
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic signed [CoordW-1:0] reg_r [8];
  logic [2:0] widx;
  assign widx = cfg_paddr[4:2];
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) reg_r[i] <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[1:0] == 2'b00) begin
      reg_r[widx] <= cfg_pwdata[CoordW-1:0];
    end
  end
  assign cfg_prdata = (cfg_paddr[1:0] == 2'b00) ?
                      {{16{reg_r[widx][CoordW-1]}}, reg_r[widx]} : '0;

  logic en;
  logic out_vld_r;
  assign en = !out_vld_r || out_tready;
  assign in_tready = en;

  // Stage 0: relative coordinates and extents.
  logic signed [RelW-1:0] ext_h, ext_v, dext_h, dext_v;
  logic src_empty, dst_empty;
  assign ext_h  = RelW'(reg_r[REG_SRC_RIGHT]) - RelW'(reg_r[REG_SRC_LEFT]);
  assign ext_v  = RelW'(reg_r[REG_SRC_BOTTOM]) - RelW'(reg_r[REG_SRC_TOP]);
  assign dext_h = RelW'(reg_r[REG_DST_RIGHT]) - RelW'(reg_r[REG_DST_LEFT]);
  assign dext_v = RelW'(reg_r[REG_DST_BOTTOM]) - RelW'(reg_r[REG_DST_TOP]);
  assign src_empty = ext_h <= 0 || ext_v <= 0;
  assign dst_empty = dext_h <= 0 || dext_v <= 0;

  logic signed [CoordW-1:0] cin [NumCh];
  always_comb begin
    cin[0] = in_tdata[15:0];
    cin[1] = in_tdata[31:16];
    cin[2] = in_tuser ? in_tdata[47:32] : '0;
    cin[3] = in_tuser ? in_tdata[63:48] : '0;
  end

  logic signed [RelW-1:0] rel_r [NumCh];
  item_ctl_t ctl0_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl0_r.vld <= 1'b0;
    end else if (en) begin
      ctl0_r.vld <= in_tvalid;
    end
    if (en) begin
      ctl0_r.rect   <= in_tuser;
      ctl0_r.mapped <= !(src_empty || dst_empty);
      ctl0_r.h_a <= cin[0];
      ctl0_r.v_a <= cin[1];
      ctl0_r.h_b <= cin[2];
      ctl0_r.v_b <= cin[3];
      for (int i = 0; i < NumCh; i++) begin
        rel_r[i] <= RelW'(cin[i]) - RelW'((i % 2 == 0) ? reg_r[REG_SRC_LEFT] : reg_r[REG_SRC_TOP]);
      end
    end
  end

  // Stage 1: product magnitude and sign.
  div_lane_t [NumCh-1:0] lane0;
  item_ctl_t ctl1_r;
  logic signed [ProdW-1:0] prod [NumCh];
  div_lane_t [NumCh-1:0] lane1_r;
  always_comb begin
    for (int i = 0; i < NumCh; i++) begin
      prod[i] = ProdW'(rel_r[i]) * ProdW'((i % 2 == 0) ? dext_h : dext_v);
      lane0[i].neg = prod[i][ProdW-1];
      lane0[i].rem = prod[i][ProdW-1] ? ProdW'(-prod[i]) : prod[i];
      lane0[i].quo = '0;
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r.vld <= 1'b0;
    end else if (en) begin
      ctl1_r <= ctl0_r;
    end
    if (en) begin
      lane1_r <= lane0;
    end
  end

  logic [ProdW-1:0] div_h, div_v;
  assign div_h = ProdW'($unsigned(ext_h));
  assign div_v = ProdW'($unsigned(ext_v));

  div_lane_t [NumCh-1:0] lane_c [QuoW+1];
  item_ctl_t ctl_c [QuoW+1];
  assign lane_c[0] = lane1_r;
  assign ctl_c[0]  = ctl1_r;

  for (genvar g = 0; g < QuoW; g++) begin : g_cell
    rrpm_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .div_h    (div_h),
      .div_v    (div_v),
      .bit_idx  (6'(QuoW-1-g)),
      .lane_in  (lane_c[g]),
      .ctl_in   (ctl_c[g]),
      .lane_out (lane_c[g+1]),
      .ctl_out  (ctl_c[g+1])
    );
  end

  // Output stage: sign, offset, wrap, order.
  item_ctl_t ce;
  logic signed [CoordW-1:0] m [NumCh];
  logic signed [CoordW-1:0] o_ha, o_va, o_hb, o_vb;
  logic [QuoW-1:0] q;
  assign ce = ctl_c[QuoW];
  always_comb begin
    for (int i = 0; i < NumCh; i++) begin
      q = lane_c[QuoW][i].neg ? QuoW'(-lane_c[QuoW][i].quo) : lane_c[QuoW][i].quo;
      m[i] = q[CoordW-1:0] + ((i % 2 == 0) ? reg_r[REG_DST_LEFT] : reg_r[REG_DST_TOP]);
    end
    if (!ce.mapped) begin
      o_ha = ce.h_a; o_va = ce.v_a; o_hb = ce.h_b; o_vb = ce.v_b;
    end else if (!ce.rect) begin
      o_ha = m[0]; o_va = m[1]; o_hb = '0; o_vb = '0;
    end else begin
      o_ha = (m[0] > m[2]) ? m[2] : m[0];
      o_hb = (m[0] > m[2]) ? m[0] : m[2];
      o_va = (m[1] > m[3]) ? m[3] : m[1];
      o_vb = (m[1] > m[3]) ? m[1] : m[3];
    end
  end

  logic [63:0] out_data_r;
  logic out_user_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= ce.vld;
    end
    if (en) begin
      out_data_r <= {o_vb, o_hb, o_va, o_ha};
      out_user_r <= ce.mapped;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

FILE: hdl/rrpm_div_cell.sv
// One restoring-division step for the four coordinate lanes.
module rrpm_div_cell
  import rrpm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic [ProdW-1:0]        div_h,   // source width, magnitude
  input  logic [ProdW-1:0]        div_v,
  input  logic [5:0]              bit_idx,
  input  div_lane_t [NumCh-1:0]   lane_in,
  input  item_ctl_t               ctl_in,
  output div_lane_t [NumCh-1:0]   lane_out,
  output item_ctl_t               ctl_out
);

  div_lane_t [NumCh-1:0] lane_r, lane_nxt;
  item_ctl_t ctl_r;

  always_comb begin
    logic [ProdW-1:0] d;
    logic [2*ProdW-1:0] sh;
    for (int i = 0; i < NumCh; i++) begin
      d = (i % 2 == 0) ? div_h : div_v;
      lane_nxt[i] = lane_in[i];
      sh = {{ProdW{1'b0}}, d} << bit_idx;
      if ({{ProdW{1'b0}}, lane_in[i].rem} >= sh) begin
        lane_nxt[i].rem = lane_in[i].rem - sh[ProdW-1:0];
        lane_nxt[i].quo[bit_idx] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.vld <= 1'b0;
    end else if (en) begin
      ctl_r <= ctl_in;
    end
    if (en) begin
      lane_r <= lane_nxt;
    end
  end

  assign lane_out = lane_r;
  assign ctl_out  = ctl_r;

endmodule

FILE: hdl/rrpm_checker.sv
// Port-level checker for the rectangle mapping core, bound to the top level.
module rrpm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic        out_tuser,
  input logic        cfg_pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while output stalled");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked with empty output");

  a_pready: assert property (@(posedge clk) cfg_pready)
    else $error("pready low");

endmodule

bind rect_to_rect_point_mapping_core rrpm_checker u_rrpm_checker (.*);

FILE: verif/tb.sv
// Testbench for the rectangle-to-rectangle point mapping core.
`timescale 1ns / 1ps

module tb;
  import rrpm_pkg::*;

  typedef struct {
    logic [15:0] h_a, v_a, h_b, v_b;
    logic        mapped;
  } map_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;   // in_h_a, in_v_a, in_h_b, in_v_b
  logic        in_tuser = 1'b0; // op
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;       // out_h_a, out_v_a, out_h_b, out_v_b
  logic        out_tuser;       // mapped
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  rect_to_rect_point_mapping_core DUT (.*);

  always #5 clk = ~clk;

  // Predictor copy of the rectangle registers
  logic signed [15:0] rect_reg [8];
  map_res_t expected_q[$];
  int  mismatches = 0;
  int  idle_pct = 0;
  int  stall_pct = 0;
  int  hold_cycles = 0;
  longint cycles = 0;

  // Handshakes sampled mid-cycle, when everything has settled
  logic        in_xfer, out_xfer, in_op_s, out_map_s;
  logic [63:0] in_data_s, out_data_s;
  always @(negedge clk) begin
    in_xfer    = in_tvalid && in_tready && rst_n;
    out_xfer   = out_tvalid && out_tready && rst_n;
    in_data_s  = in_tdata;
    in_op_s    = in_tuser;
    out_data_s = out_tdata;
    out_map_s  = out_tuser;
  end

  function automatic logic [15:0] scale_coord(logic signed [15:0] c, logic signed [15:0] s0,
                                              logic signed [15:0] s1, logic signed [15:0] d0,
                                              logic signed [15:0] d1);
    longint rel, prod, quo, sum;
    rel  = longint'(c) - longint'(s0);
    prod = rel * (longint'(d1) - longint'(d0));
    quo  = prod / (longint'(s1) - longint'(s0));
    sum  = longint'(d0) + quo;
    return sum[15:0];
  endfunction

  function automatic map_res_t map_item(logic op, logic [63:0] d);
    map_res_t r;
    logic [15:0] t;
    logic empty;
    r.h_a = d[15:0];
    r.v_a = d[31:16];
    r.h_b = op ? d[47:32] : 16'd0;
    r.v_b = op ? d[63:48] : 16'd0;
    empty = rect_reg[REG_SRC_LEFT] >= rect_reg[REG_SRC_RIGHT]
         || rect_reg[REG_SRC_TOP] >= rect_reg[REG_SRC_BOTTOM]
         || rect_reg[REG_DST_LEFT] >= rect_reg[REG_DST_RIGHT]
         || rect_reg[REG_DST_TOP] >= rect_reg[REG_DST_BOTTOM];
    r.mapped = !empty;
    if (!empty) begin
      r.h_a = scale_coord(r.h_a, rect_reg[REG_SRC_LEFT], rect_reg[REG_SRC_RIGHT],
                          rect_reg[REG_DST_LEFT], rect_reg[REG_DST_RIGHT]);
      r.v_a = scale_coord(r.v_a, rect_reg[REG_SRC_TOP], rect_reg[REG_SRC_BOTTOM],
                          rect_reg[REG_DST_TOP], rect_reg[REG_DST_BOTTOM]);
      if (op) begin
        r.h_b = scale_coord(r.h_b, rect_reg[REG_SRC_LEFT], rect_reg[REG_SRC_RIGHT],
                            rect_reg[REG_DST_LEFT], rect_reg[REG_DST_RIGHT]);
        r.v_b = scale_coord(r.v_b, rect_reg[REG_SRC_TOP], rect_reg[REG_SRC_BOTTOM],
                            rect_reg[REG_DST_TOP], rect_reg[REG_DST_BOTTOM]);
        if ($signed(r.h_a) > $signed(r.h_b)) begin
          t = r.h_a; r.h_a = r.h_b; r.h_b = t;
        end
        if ($signed(r.v_a) > $signed(r.v_b)) begin
          t = r.v_a; r.v_a = r.v_b; r.v_b = t;
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (in_xfer) expected_q.push_back(map_item(in_op_s, in_data_s));
  end

  // Result checker
  always @(posedge clk) begin
    map_res_t e;
    if (out_xfer) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h mapped=%b", out_data_s, out_map_s);
      end else begin
        e = expected_q.pop_front();
        if (out_data_s !== {e.v_b, e.h_b, e.v_a, e.h_a} || out_map_s !== e.mapped) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %h/%h/%h/%h m=%b, got %h/%h/%h/%h m=%b",
                     e.h_a, e.v_a, e.h_b, e.v_b, e.mapped, out_data_s[15:0],
                     out_data_s[31:16], out_data_s[47:32], out_data_s[63:48], out_map_s);
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready  <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  task automatic send_item(logic op, logic [15:0] ha, logic [15:0] va,
                           logic [15:0] hb, logic [15:0] vb);
    if ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {vb, hb, va, ha};
    do @(posedge clk); while (!in_xfer);
  endtask

  task automatic send_random(int n);
    for (int i = 0; i < n; i++)
      send_item(1'($urandom_range(1)), 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom));
  endtask

  // Stop offering, let every result arrive, then allow the pipe to empty
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {{16{val[15]}}, val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    rect_reg[idx] = val;
  endtask

  task automatic set_rects(logic [15:0] sl, st, sr, sb, dl, dt, dr, db);
    write_reg(REG_SRC_LEFT, sl);
    write_reg(REG_SRC_TOP, st);
    write_reg(REG_SRC_RIGHT, sr);
    write_reg(REG_SRC_BOTTOM, sb);
    write_reg(REG_DST_LEFT, dl);
    write_reg(REG_DST_TOP, dt);
    write_reg(REG_DST_RIGHT, dr);
    write_reg(REG_DST_BOTTOM, db);
  endtask

  // Mostly well-formed edges; now and then an arbitrary (possibly empty) pair
  task automatic rand_edges(output logic [15:0] lo, output logic [15:0] hi);
    logic [15:0] a, b;
    a = 16'($urandom);
    b = 16'($urandom);
    if ($urandom_range(9) == 0 || a == b) begin
      lo = a; hi = b;
    end else if ($signed(a) < $signed(b)) begin
      lo = a; hi = b;
    end else begin
      lo = b; hi = a;
    end
  endtask

  task automatic random_rects();
    logic [15:0] sl, st, sr, sb, dl, dt, dr, db;
    rand_edges(sl, sr);
    rand_edges(st, sb);
    rand_edges(dl, dr);
    rand_edges(dt, db);
    set_rects(sl, st, sr, sb, dl, dt, dr, db);
  endtask

  // Registers at reset describe empty rectangles: everything passes through
  task automatic test_passthrough();
    send_item(1'b0, 16'h8000, 16'h7fff, 16'h1234, 16'hffff);
    send_item(1'b1, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
    drain();
    // destination zero width
    set_rects(16'd0, 16'd0, 16'd100, 16'd100, 16'd10, 16'd10, 16'd10, 16'd50);
    send_item(1'b1, 16'd90, 16'd80, 16'd5, 16'd2);
    drain();
    // source zero height
    set_rects(16'd0, 16'd20, 16'd100, 16'd20, 16'd0, 16'd0, 16'd10, 16'd10);
    send_item(1'b0, 16'd3, 16'd4, 16'd5, 16'd6);
    drain();
  endtask

  task automatic test_scaling();
    set_rects(16'd0, 16'd0, 16'd100, 16'd100, -16'sd50, 16'd0, 16'd150, 16'd50);
    send_item(1'b0, 16'd0, 16'd0, 16'hffff, 16'hffff);
    send_item(1'b0, 16'd99, 16'd100, 16'd0, 16'd0);
    send_item(1'b0, -16'sd7, -16'sd3, 16'd0, 16'd0);  // truncation toward zero
    send_item(1'b1, 16'd80, 16'd90, 16'd10, 16'd20);  // corners swapped
    send_item(1'b1, 16'd10, 16'd20, 16'd80, 16'd90);
    send_item(1'b1, 16'd30, 16'd30, 16'd30, 16'd30);
    drain();
  endtask

  task automatic test_extremes();
    set_rects(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
    send_item(1'b1, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
    send_item(1'b0, 16'h0000, 16'hffff, 16'h0000, 16'h0000);
    drain();
    // Tiny source onto huge destination: sums wrap
    set_rects(16'd0, 16'hffff, 16'd1, 16'd0, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
    send_item(1'b1, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
    send_item(1'b0, 16'h4000, 16'h3fff, 16'd0, 16'd0);
    drain();
    set_rects(16'h7ffe, 16'h7ffe, 16'h7fff, 16'h7fff, 16'h7ffe, 16'h8000, 16'h7fff, 16'h8001);
    send_item(1'b1, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
    drain();
  endtask

  task automatic test_random_phases();
    int idle_set [4]  = '{0, 87, 0, 22};
    int stall_set [4] = '{0, 0, 87, 22};
    for (int p = 0; p < 4; p++) begin
      idle_pct  = idle_set[p];
      stall_pct = stall_set[p];
      for (int k = 0; k < 4; k++) begin
        random_rects();
        send_random(90);
        drain();
      end
    end
    idle_pct  = 0;
    stall_pct = 0;
  endtask

  // Long receiver hold-off while items keep coming, so the input stalls
  task automatic test_backpressure();
    random_rects();
    hold_cycles = 400;
    send_random(120);
    drain();
    send_random(40);
  endtask

  initial begin
    for (int i = 0; i < 8; i++) rect_reg[i] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_passthrough();
    test_scaling();
    test_extremes();
    test_random_phases();
    test_backpressure();
    drain();
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/rrpm_pkg.sv
hdl/rrpm_div_cell.sv
hdl/rect_to_rect_point_mapping_core.sv
hdl/rrpm_checker.sv
verif/tb.sv
